// ----- sv/mgcq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the move-gated command queue.
package mgcq_pkg;

	localparam int DEPTH     = 16;
	localparam int MAX_BYTES = 64;

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SLEN_W = $clog2(MAX_BYTES + 1);

	localparam logic [1:0] OP_ENQ   = 2'd0;
	localparam logic [1:0] OP_DEQ   = 2'd1;
	localparam logic [1:0] OP_PURGE = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_READY = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] scheduled_moves;
		logic [31:0] completed_moves;
		logic [63:0] entry_data;
		logic [7:0]  entry_length;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] out_data;
		logic [6:0]  out_length;
		logic        idle;
		logic [4:0]  occupancy;
		logic [4:0]  purged_count;
	} res_t;

	// One queue entry as it sits in the entry memory.
	typedef struct packed {
		logic [31:0]       tag;
		logic [63:0]       handle;
		logic [SLEN_W-1:0] len;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ,
		ST_PURGE,
		ST_CHK,
		ST_RESP
	} state_t;

	// Ring position of the entry that lies off places after the head.
	function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

// ----- sv/mgcq_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
module mgcq_ram #(
	parameter int WIDTH   = 8,
	parameter int ENTRIES = 16,
	parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/move_gated_command_queue.sv -----
`timescale 1ns / 1ps
// Top level of the move-gated command queue: sequencer, entry memory and result register.
//
//   channel  | handshake            | payload            | direction
//   ---------+----------------------+--------------------+----------
//   command  | cmd_valid, cmd_stall | cmd (cmd_t)        | in
//   result   | res_valid, res_stall | res (res_t)        | out
//
// From acceptance, an enqueue passes the execute, check and response states,
// a clear execute and response. A dequeue goes from execute to response on an
// empty queue, through dequeue to response when the head is not due or the last
// entry leaves, and through dequeue and check otherwise. A purge walks the held
// entries through the single read port of the entry memory, one entry a cycle,
// then goes to check, or to response when no entry survives.
// Reset clears the head pointer and the count at once; the entry memory is not
// cleared, since only written entries are ever read. While a result is still
// stalled the next request is taken and worked on; it then waits in its last
// state until the result register frees.
module move_gated_command_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  mgcq_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output mgcq_pkg::res_t res
);

	import mgcq_pkg::*;

	// Sequencer state and queue pointers.
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  walk_q;
	logic [CNT_W-1:0]  kept_q;
	logic              rd_v_s1;

	// Latched request and the result being built.
	cmd_t              cmd_q;
	logic [1:0]        status_q;
	logic [63:0]       rel_data_q;
	logic [SLEN_W-1:0] rel_len_q;
	logic              idle_q;
	logic [CNT_W-1:0]  removed_q;

	logic              res_valid_q;
	res_t              res_q;

	// Entry memory ports and the write-to-read bypass.
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_wdata;
	entry_t            mem_rdata;
	logic              byp_v_s1;
	entry_t            byp_e_s1;
	entry_t            rd_e;

	logic              cmd_fire;
	logic              res_free;
	logic              due;
	logic              drop;
	logic              walk_more;
	logic              walk_done;
	logic [SLEN_W-1:0] len_clamped;

	mgcq_ram #(
		.WIDTH   ($bits(entry_t)),
		.ENTRIES (DEPTH),
		.ADDR_W  (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A read of the slot written in the same cycle would return stale data,
	// so the written entry is carried alongside and takes precedence.
	assign rd_e = byp_v_s1 ? byp_e_s1 : mem_rdata;

	// The entry at the read port is due once completed moves reach its tag.
	assign due  = !(rd_e.tag > cmd_q.completed_moves);
	// A purge drops every entry scheduled after the current scheduled count.
	assign drop = rd_e.tag > cmd_q.scheduled_moves;

	assign walk_more = walk_q < count_q;
	assign walk_done = !walk_more && !rd_v_s1;

	assign len_clamped = (cmd_q.entry_length > 8'(MAX_BYTES)) ?
		SLEN_W'(MAX_BYTES) : SLEN_W'(cmd_q.entry_length);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_q.op)
					OP_ENQ:   state_d = ST_CHK;
					OP_DEQ:   state_d = (count_q == '0) ? ST_RESP : ST_DEQ;
					OP_PURGE: state_d = ST_PURGE;
					OP_CLEAR: state_d = ST_RESP;
					default:  state_d = ST_RESP;
				endcase
			end
			ST_DEQ: begin
				if (!due || count_q == CNT_W'(1)) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_PURGE: begin
				if (walk_done) begin
					state_d = (kept_q == '0) ? ST_RESP : ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory control. The default read address is the head, so that the
	// result check after an operation finds the head tag in the next cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_at(head_q, count_q);
		mem_wdata = '{tag: cmd_q.scheduled_moves, handle: cmd_q.entry_data,
			len: len_clamped};
		mem_raddr = head_q;
		case (state_q)
			ST_EXEC: begin
				if (cmd_q.op == OP_ENQ && count_q < CNT_W'(DEPTH)) begin
					mem_we = 1'b1;
				end
			end
			ST_DEQ: begin
				mem_raddr = slot_at(head_q, CNT_W'(1));
			end
			ST_PURGE: begin
				// Kept entries close up toward the head. The write slot never
				// runs ahead of the read slot, so no entry is overwritten unread.
				if (walk_more) begin
					mem_raddr = slot_at(head_q, walk_q);
				end
				if (rd_v_s1 && !drop) begin
					mem_we    = 1'b1;
					mem_waddr = slot_at(head_q, kept_q);
					mem_wdata = rd_e;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			walk_q  <= '0;
			kept_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_EXEC: begin
					walk_q  <= '0;
					kept_q  <= '0;
					rd_v_s1 <= 1'b0;
					if (cmd_q.op == OP_ENQ && count_q < CNT_W'(DEPTH)) begin
						count_q <= count_q + CNT_W'(1);
					end else if (cmd_q.op == OP_CLEAR) begin
						count_q <= '0;
					end
				end
				ST_DEQ: begin
					if (due) begin
						head_q  <= slot_at(head_q, CNT_W'(1));
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_PURGE: begin
					rd_v_s1 <= walk_more;
					if (walk_more) begin
						walk_q <= walk_q + CNT_W'(1);
					end
					if (rd_v_s1 && !drop) begin
						kept_q <= kept_q + CNT_W'(1);
					end
					if (walk_done) begin
						count_q <= kept_q;
					end
				end
				default: begin
					rd_v_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Request latch and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					cmd_q <= cmd;
				end
			end
			ST_EXEC: begin
				rel_data_q <= '0;
				rel_len_q  <= '0;
				removed_q  <= (cmd_q.op == OP_CLEAR) ? count_q : '0;
				case (cmd_q.op)
					OP_ENQ: begin
						status_q <= (count_q >= CNT_W'(DEPTH)) ? STAT_FULL : STAT_DONE;
					end
					OP_DEQ: begin
						if (count_q == '0) begin
							status_q <= STAT_NOT_READY;
							idle_q   <= 1'b1;
						end else begin
							status_q <= STAT_DONE;
						end
					end
					OP_PURGE: begin
						status_q <= STAT_DONE;
					end
					OP_CLEAR: begin
						status_q <= STAT_DONE;
						idle_q   <= 1'b1;
					end
					default: begin
						status_q <= STAT_DONE;
						idle_q   <= 1'b1;
					end
				endcase
			end
			ST_DEQ: begin
				if (!due) begin
					status_q <= STAT_NOT_READY;
					idle_q   <= 1'b1;
				end else begin
					rel_data_q <= rd_e.handle;
					rel_len_q  <= rd_e.len;
					if (count_q == CNT_W'(1)) begin
						idle_q <= 1'b1;
					end
				end
			end
			ST_PURGE: begin
				if (rd_v_s1 && drop) begin
					removed_q <= removed_q + CNT_W'(1);
				end
				if (walk_done && kept_q == '0) begin
					idle_q <= 1'b1;
				end
			end
			ST_CHK: begin
				idle_q <= !due;
			end
			default: begin
				idle_q <= idle_q;
			end
		endcase
	end

	// Same-slot bypass for a read issued in the cycle of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_s1 <= 1'b0;
		end else begin
			byp_v_s1 <= mem_we && (mem_waddr == mem_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_e_s1 <= mem_wdata;
	end

	// Result register: loads when the sequencer finishes and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && res_free) begin
			res_q.status       <= status_q;
			res_q.out_data     <= rel_data_q;
			res_q.out_length   <= 7'(rel_len_q);
			res_q.idle         <= idle_q;
			res_q.occupancy    <= 5'(count_q);
			res_q.purged_count <= 5'(removed_q);
		end
	end

endmodule

// ----- sv/mgcq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the move-gated command queue and their bind to the top level.
module mgcq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input mgcq_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_stall,
	input mgcq_pkg::res_t res
);

	import mgcq_pkg::*;

	// A stalled result keeps its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// The queue works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("request taken while another is in progress");

	// A full report comes only with a full queue.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STAT_FULL |-> res.occupancy == 5'(DEPTH))
		else $error("full status with room left");

	// A failed dequeue releases nothing and leaves the queue idle.
	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STAT_NOT_READY |->
		res.out_data == '0 && res.out_length == '0 && res.idle)
		else $error("failed dequeue released data");

	// Occupancy never exceeds the pool and an empty queue is idle.
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.occupancy <= 5'(DEPTH) && (res.occupancy != '0 || res.idle))
		else $error("occupancy out of range or empty queue not idle");

endmodule

bind move_gated_command_queue mgcq_checker u_mgcq_checker (.*);
